>>> sv/hamming_ball_bitset_search_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Hamming ball bitset search
// Clocked concurrent checks, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef HAMMING_BALL_BITSET_SEARCH_ASSERT_SVH
`define HAMMING_BALL_BITSET_SEARCH_ASSERT_SVH

// Check a property on every rising edge once reset has been released.
`define HBBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define HBBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/hbbs_pkg.sv
// ----------------------------------------------------------------------------
// hbbs_pkg
// Shared constants, microcode types and the microcode table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbbs_pkg;

  localparam int KEY_BITS_DEF = 16;
  localparam int MAX_RADIUS   = 2;
  localparam int COUNT_W      = 10;
  localparam int WORD_BITS    = 32;
  localparam int BIT_IDX_W    = 5;
  localparam int RADIUS_W     = 2;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(2);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_RAD,
    S_LOOPI,
    S_LOOPJ,
    S_NEXTI,
    S_OUT,
    S_BACK,
    S_INS
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_INSERT,
    C_RAD0,
    C_NO_J,
    C_J_NZ,
    C_I_NZ
  } cond_t;

  typedef enum logic [1:0] {
    P_NONE,
    P_REF,
    P_I,
    P_IJ
  } psel_t;

  typedef struct packed {
    logic  take;
    psel_t psel;
    logic  load_i;
    logic  dec_i;
    logic  load_j;
    logic  dec_j;
    logic  write;
    logic  load_out;
    logic  out_wait;
    cond_t cond;
    step_t target;
  } ucw_t;

  // Microcode: one control word per step.
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    w = '{take: 1'b0, psel: P_NONE, load_i: 1'b0, dec_i: 1'b0, load_j: 1'b0,
          dec_j: 1'b0, write: 1'b0, load_out: 1'b0, out_wait: 1'b0,
          cond: C_NEVER, target: S_IDLE};
    case (s)
      S_IDLE: begin
        w.take   = 1'b1;
        w.cond   = C_NO_ITEM;
        w.target = S_IDLE;
      end
      S_DISP: begin
        w.psel   = P_REF;
        w.load_i = 1'b1;
        w.cond   = C_INSERT;
        w.target = S_INS;
      end
      S_RAD: begin
        w.cond   = C_RAD0;
        w.target = S_OUT;
      end
      S_LOOPI: begin
        w.psel   = P_I;
        w.load_j = 1'b1;
        w.cond   = C_NO_J;
        w.target = S_NEXTI;
      end
      S_LOOPJ: begin
        w.psel   = P_IJ;
        w.dec_j  = 1'b1;
        w.cond   = C_J_NZ;
        w.target = S_LOOPJ;
      end
      S_NEXTI: begin
        w.dec_i  = 1'b1;
        w.cond   = C_I_NZ;
        w.target = S_LOOPI;
      end
      S_OUT: begin
        w.load_out = 1'b1;
        w.out_wait = 1'b1;
        w.cond     = C_NEVER;
        w.target   = S_OUT;
      end
      S_BACK: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_INS: begin
        w.write  = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_OUT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> sv/hbbs_if.sv
// ----------------------------------------------------------------------------
// hbbs_if
// Valid/ready channels for items, results and the radius register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hbbs_in_if #(parameter int KEY_BITS = hbbs_pkg::KEY_BITS_DEF) ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [KEY_BITS-1:0] key;
  modport source (output valid, mode, key, input ready);
  modport sink   (input valid, mode, key, output ready);
endinterface

interface hbbs_out_if #(parameter int KEY_BITS = hbbs_pkg::KEY_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic                         any_match;
  logic [hbbs_pkg::COUNT_W-1:0] match_count;
  logic [KEY_BITS-1:0]          last_match;
  modport source (output valid, any_match, match_count, last_match, input ready);
  modport sink   (input valid, any_match, match_count, last_match, output ready);
endinterface

interface hbbs_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [hbbs_pkg::RADIUS_W-1:0] max_distance;
  modport source (output valid, max_distance, input ready);
  modport sink   (input valid, max_distance, output ready);
endinterface

>>> sv/hbbs_ram.sv
// ----------------------------------------------------------------------------
// hbbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hamming_ball_bitset_search.sv
// ----------------------------------------------------------------------------
// hamming_ball_bitset_search
// Membership bitset with insert and Hamming-ball neighbour query.
// ----------------------------------------------------------------------------
// Use: send items on in_ch (mode 0 inserts key, mode 1 queries around key).
// Every item yields exactly one result transaction on out_ch: for a query the
// hit count, a found flag and the last hit in probe order; for an insert zeros.
// cfg_ch writes max_distance (0..2, larger values act as 2); write it only
// while the block is idle. cfg_ch.ready is always high.
// Sequence: an insert reads the key's bitset word, writes it back with the
// key's bit set and loads a zero result. A query probes the key itself, then
// at radius 1 or 2 each single flip from the top bit down, at radius 2 each
// followed by its double flips on lower bits, and loads the tally. From the
// output step the sequencer passes S_BACK and returns to idle, and only then
// takes a new item. The bitset RAM gives one word read per cycle and the
// microcode issues at most one probe per step; one item is in work at a time.
// Reset: the 2^(K-5) bitset words (2048 at 16 bits, one for K below 6) are
// swept to zero one word per cycle, with in_ch.ready low meanwhile.
// Stall: a result waits in the output register; the next item is taken and
// searched, and the sequencer holds in its output step until the register
// frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hamming_ball_bitset_search_assert.svh"

module hamming_ball_bitset_search #(
  parameter int KEY_BITS = hbbs_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hbbs_in_if.sink     in_ch,
  hbbs_out_if.source  out_ch,
  hbbs_cfg_if.sink    cfg_ch
);

  import hbbs_pkg::*;

  // Bitset geometry: key k lives in bit k[4:0] of word k >> 5.
  localparam int WORDS = (KEY_BITS > BIT_IDX_W) ? (1 << (KEY_BITS - BIT_IDX_W)) : 1;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW    = $clog2(KEY_BITS);
  localparam int XW    = KEY_BITS + BIT_IDX_W;

  // Sequencer and control state
  step_t                upc_r, upc_nxt;
  logic                 clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [RADIUS_W-1:0]  max_dist_r, max_dist_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Datapath registers
  logic                 mode_r, mode_nxt;
  logic [KEY_BITS-1:0]  ref_r, ref_nxt;
  logic [IW-1:0]        i_r, i_nxt;
  logic [IW-1:0]        j_r, j_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [KEY_BITS-1:0]  last_r, last_nxt;
  logic [KEY_BITS-1:0]  pkey_r, pkey_nxt;
  logic                 o_any_r, o_any_nxt;
  logic [COUNT_W-1:0]   o_cnt_r, o_cnt_nxt;
  logic [KEY_BITS-1:0]  o_last_r, o_last_nxt;

  ucw_t                 uw;
  logic                 in_fire, out_fire, out_busy, taken, hit, load_out;
  logic [RADIUS_W-1:0]  rad_eff;
  logic [KEY_BITS-1:0]  probe_key;
  logic [XW-1:0]        probe_ext, pkey_ext, ref_ext;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  assign uw       = ucode(upc_r);
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;
  assign out_busy = out_valid_r & ~out_ch.ready;
  assign load_out = uw.load_out & ~out_busy;

  assign in_ch.ready        = uw.take & ~clr_busy_r;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.any_match   = o_any_r;
  assign out_ch.match_count = o_cnt_r;
  assign out_ch.last_match  = o_last_r;

  // Saturate the radius to what the sequence supports.
  assign rad_eff = (max_dist_r > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : max_dist_r;

  // Probe key for this step.
  always_comb begin
    case (uw.psel)
      P_I:     probe_key = ref_r ^ (KEY_BITS'(1) << i_r);
      P_IJ:    probe_key = ref_r ^ (KEY_BITS'(1) << i_r) ^ (KEY_BITS'(1) << j_r);
      default: probe_key = ref_r;
    endcase
  end

  assign probe_ext = {{BIT_IDX_W{1'b0}}, probe_key};
  assign pkey_ext  = {{BIT_IDX_W{1'b0}}, pkey_r};
  assign ref_ext   = {{BIT_IDX_W{1'b0}}, ref_r};

  // Read data returns in the cycle after the probe; count only for queries.
  assign hit = pend_r & (mode_r == MODE_QUERY) & ram_rdata[pkey_ext[BIT_IDX_W-1:0]];

  // Jump condition
  always_comb begin
    case (uw.cond)
      C_ALWAYS:  taken = 1'b1;
      C_NO_ITEM: taken = ~in_fire;
      C_INSERT:  taken = (mode_r == MODE_INSERT);
      C_RAD0:    taken = (rad_eff == '0);
      C_NO_J:    taken = (rad_eff < RADIUS_W'(2)) || (i_r == '0);
      C_J_NZ:    taken = (j_r != '0);
      C_I_NZ:    taken = (i_r != '0);
      default:   taken = 1'b0;
    endcase
  end

  // RAM port: clearing sweep owns the write port after reset.
  always_comb begin
    ram_raddr = probe_ext[AW+BIT_IDX_W-1:BIT_IDX_W];
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = uw.write;
      ram_waddr = ref_ext[AW+BIT_IDX_W-1:BIT_IDX_W];
      ram_wdata = ram_rdata | (WORD_BITS'(1) << ref_ext[BIT_IDX_W-1:0]);
    end
  end

  always_comb begin
    upc_nxt       = upc_r;
    clr_busy_nxt  = clr_busy_r;
    clr_addr_nxt  = clr_addr_r;
    max_dist_nxt  = max_dist_r;
    pend_nxt      = (uw.psel != P_NONE);
    out_valid_nxt = out_valid_r;
    mode_nxt      = mode_r;
    ref_nxt       = ref_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    pkey_nxt      = probe_key;
    o_any_nxt     = o_any_r;
    o_cnt_nxt     = o_cnt_r;
    o_last_nxt    = o_last_r;

    // Advance the step counter; hold in the output step while it is blocked.
    if (uw.out_wait && out_busy) begin
      upc_nxt = upc_r;
    end else if (taken) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = step_t'(upc_r + 4'd1);
    end

    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    if (cfg_ch.valid) begin
      max_dist_nxt = cfg_ch.max_distance;
    end

    // Latch the item and clear the tallies.
    if (in_fire) begin
      mode_nxt  = in_ch.mode;
      ref_nxt   = in_ch.key;
      count_nxt = '0;
      last_nxt  = '0;
    end

    if (hit) begin
      count_nxt = count_r + COUNT_W'(1);
      last_nxt  = pkey_r;
    end

    if (uw.load_i) begin
      i_nxt = IW'(KEY_BITS - 1);
    end else if (uw.dec_i) begin
      i_nxt = i_r - IW'(1);
    end

    if (uw.load_j) begin
      j_nxt = i_r - IW'(1);
    end else if (uw.dec_j) begin
      j_nxt = j_r - IW'(1);
    end

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      o_any_nxt     = (count_r != '0);
      o_cnt_nxt     = count_r;
      o_last_nxt    = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      max_dist_r  <= RADIUS_RST;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      max_dist_r  <= max_dist_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    ref_r    <= ref_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    count_r  <= count_nxt;
    last_r   <= last_nxt;
    pkey_r   <= pkey_nxt;
    o_any_r  <= o_any_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_last_r <= o_last_nxt;
  end

  hbbs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitset (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `HBBS_ASSERT(a_no_take_while_clearing, clr_busy_r |-> !in_fire, "item taken during clearing sweep")
  `HBBS_ASSERT(a_insert_result_zero, (load_out && (mode_r == MODE_INSERT)) |-> (count_r == '0), "insert result carries hits")
  `HBBS_ASSERT(a_found_matches_count, out_valid_r |-> (o_any_r == (o_cnt_r != '0)), "found flag disagrees with count")
  `HBBS_ASSERT(a_write_only_insert, (ram_we && !clr_busy_r) |-> (mode_r == MODE_INSERT), "bitset written outside insert")
  `HBBS_ASSERT(a_no_probe_when_idle, (upc_r == S_IDLE) |=> !pend_r || (upc_r == S_DISP), "probe pending without item")

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: Hamming ball bitset search testbench
// Drives inserts and neighbour queries through the valid/ready channels. A
// local copy of the membership bitset predicts each search in probe order,
// and the results are checked in order, field by field. The radius register
// is stepped through every value across phases with and without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hbbs_pkg::*;

  localparam int KEY_W    = KEY_BITS_DEF;
  localparam int N_PHASES = 8;

  typedef struct packed {
    logic               any_match;
    logic [COUNT_W-1:0] match_count;
    logic [KEY_W-1:0]   last_match;
  } search_result_t;

  // Predict each transaction's result from a private copy of the key set and
  // the radius; keep the predictions in arrival order.
  class ball_search_checker;
    bit                  key_present [0:(1 << KEY_W) - 1];
    logic [RADIUS_W-1:0] radius;
    search_result_t      expected_results [$];
    int                  error_count;

    function new();
      radius      = RADIUS_RST;
      error_count = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void set_radius(logic [RADIUS_W-1:0] value);
      radius = value;
    endfunction

    function void probe(input logic [KEY_W-1:0] k, inout int hits,
                        inout logic [KEY_W-1:0] last_hit);
      if (key_present[k]) begin
        hits++;
        last_hit = k;
      end
    endfunction

    // Walk the ball depth first: centre, then each single flip from the top
    // bit down, each followed by its double flips on lower bits.
    function search_result_t search_ball(logic [KEY_W-1:0] centre);
      search_result_t   res;
      int               reach;
      int               hits;
      int               i;
      int               j;
      logic [KEY_W-1:0] last_hit;
      logic [KEY_W-1:0] k1;
      reach    = (radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
      hits     = 0;
      last_hit = '0;
      probe(centre, hits, last_hit);
      if (reach >= 1) begin
        for (i = KEY_W - 1; i >= 0; i--) begin
          k1 = centre ^ (KEY_W'(1) << i);
          probe(k1, hits, last_hit);
          if (reach >= 2) begin
            for (j = i - 1; j >= 0; j--) probe(k1 ^ (KEY_W'(1) << j), hits, last_hit);
          end
        end
      end
      res.any_match   = (hits != 0);
      res.match_count = COUNT_W'(hits);
      res.last_match  = last_hit;
      return res;
    endfunction

    function void note_item(logic mode, logic [KEY_W-1:0] key);
      if (mode == MODE_INSERT) begin
        key_present[key] = 1'b1;
        expected_results.push_back('0);
      end else begin
        expected_results.push_back(search_ball(key));
      end
    endfunction

    function void check_result(logic any_match, logic [COUNT_W-1:0] match_count,
                               logic [KEY_W-1:0] last_match);
      search_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("unexpected result: any_match %0d match_count %0d last_match 0x%04h",
               any_match, match_count, last_match);
        error_count++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (any_match !== exp_res.any_match) begin
        $error("any_match: expected %0d, got %0d", exp_res.any_match, any_match);
        error_count++;
      end
      if (match_count !== exp_res.match_count) begin
        $error("match_count: expected %0d, got %0d", exp_res.match_count, match_count);
        error_count++;
      end
      if (last_match !== exp_res.last_match) begin
        $error("last_match: expected 0x%04h, got 0x%04h", exp_res.last_match, last_match);
        error_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hbbs_in_if  in_ch ();
  hbbs_out_if out_ch ();
  hbbs_cfg_if cfg_ch ();

  hamming_ball_bitset_search uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ball_search_checker sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;

  // Radius and idling per phase; 3 exercises the saturation to the limit.
  logic [RADIUS_W-1:0] phase_radius [N_PHASES] =
    '{2'd2, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2};
  int                  idle_pct_tab [4]        = '{0, 51, 0, 32};
  int                  stall_pct_tab [4]       = '{0, 0, 51, 32};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block locks up.
  initial begin
    #30_000_000;
    $display("FAIL hamming_ball_bitset_search");
    $finish;
  end

  // Receiver: stall at random, at the rate the current phase asks for.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitors: sample the handshakes at the edge, before any driver update.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_item(in_ch.mode, in_ch.key);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.any_match, out_ch.match_count, out_ch.last_match);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) sb.set_radius(cfg_ch.max_distance);
  end

  // Offer one transaction, after random gaps; leave valid high on return so
  // that back-to-back transactions need no extra edge.
  task automatic send_item(logic mode, logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.key   <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every outstanding result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write the radius only once the block has gone quiet.
  task automatic write_radius(logic [RADIUS_W-1:0] value);
    drain_results();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.max_distance <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] flip_mask(int flips);
    logic [KEY_W-1:0] mask;
    mask = '0;
    repeat (flips) mask ^= KEY_W'(1) << $urandom_range(KEY_W - 1);
    return mask;
  endfunction

  // Directed: empty-set miss, zero and all-ones keys, duplicate insert, hits
  // at each distance, and the same search at every radius including 3.
  task automatic run_directed();
    send_item(MODE_QUERY,  16'h0000);
    send_item(MODE_INSERT, 16'h0000);
    send_item(MODE_INSERT, 16'h0000);
    send_item(MODE_QUERY,  16'h0000);
    send_item(MODE_INSERT, 16'hFFFF);
    send_item(MODE_QUERY,  16'hFFFF);
    send_item(MODE_INSERT, 16'h0003);
    send_item(MODE_INSERT, 16'h8000);
    send_item(MODE_QUERY,  16'h0000);
    send_item(MODE_QUERY,  16'h0001);
    send_item(MODE_INSERT, 16'h7FFF);
    send_item(MODE_QUERY,  16'hFFFF);
    send_item(MODE_QUERY,  16'h5A5A);
    write_radius(2'd1);
    send_item(MODE_QUERY,  16'h0000);
    send_item(MODE_QUERY,  16'h8001);
    write_radius(2'd0);
    send_item(MODE_QUERY,  16'h0000);
    send_item(MODE_QUERY,  16'h0001);
    write_radius(2'd3);
    send_item(MODE_QUERY,  16'h0000);
    send_item(MODE_QUERY,  16'hFFFC);
  endtask

  // Insert every key of the radius-2 ball, then search its centre and one neighbour.
  task automatic fill_ball(logic [KEY_W-1:0] centre);
    int               i;
    int               j;
    logic [KEY_W-1:0] k1;
    send_item(MODE_INSERT, centre);
    for (i = KEY_W - 1; i >= 0; i--) begin
      k1 = centre ^ (KEY_W'(1) << i);
      send_item(MODE_INSERT, k1);
      for (j = i - 1; j >= 0; j--) send_item(MODE_INSERT, k1 ^ (KEY_W'(1) << j));
    end
    send_item(MODE_QUERY, centre);
    send_item(MODE_QUERY, centre ^ flip_mask(1));
  endtask

  // Mostly clusters: a few inserts around a centre, then searches near it.
  // The rest is lone inserts and searches at random keys.
  task automatic run_random(int quota);
    int               stop_at;
    int               pick;
    logic [KEY_W-1:0] centre;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        centre = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
        repeat ($urandom_range(1, 6)) send_item(MODE_INSERT, centre ^ flip_mask($urandom_range(3)));
        repeat ($urandom_range(1, 4)) send_item(MODE_QUERY, centre ^ flip_mask($urandom_range(2)));
      end else if (pick < 85) begin
        send_item(MODE_INSERT, KEY_W'($urandom_range(0, (1 << KEY_W) - 1)));
      end else begin
        send_item(MODE_QUERY, KEY_W'($urandom_range(0, (1 << KEY_W) - 1)));
      end
      if ($urandom_range(99) < 3) drain_results();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_INSERT;
    in_ch.key           = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.max_distance = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    items_sent          = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int phase = 0; phase < N_PHASES; phase++) begin
      write_radius(phase_radius[phase]);
      send_idle_pct  = idle_pct_tab[phase % 4];
      recv_stall_pct = stall_pct_tab[phase % 4];
      if (phase == 0) fill_ball(KEY_W'($urandom_range(0, (1 << KEY_W) - 1)));
      run_random(250);
    end

    // Let the last search finish and catch any stray result.
    drain_results();
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("PASS hamming_ball_bitset_search");
    end else begin
      $display("FAIL hamming_ball_bitset_search");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/hbbs_pkg.sv
sv/hbbs_if.sv
sv/hbbs_ram.sv
sv/hamming_ball_bitset_search.sv
tb/tb_top.sv
